// ----- rtl/pfaq_pkg.sv -----
package pfaq_pkg;

  // sizes
  localparam int NUM_PAGES = 1024;
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 11;
  localparam int QUOTA_W   = 11;
  localparam int PSTATE_W  = 2;
  localparam int STATUS_W  = 3;

  // quota reset values
  localparam logic [QUOTA_W-1:0] DRIVER_QUOTA_RST = QUOTA_W'(8);
  localparam logic [QUOTA_W-1:0] KERN_QUOTA_RST   = QUOTA_W'(8);

  // configuration register indexes
  localparam logic REG_DRIVER_QUOTA = 1'b0;
  localparam logic REG_KERN_QUOTA   = 1'b1;

  // operations
  localparam logic [1:0] OP_ALLOC       = 2'd0;
  localparam logic [1:0] OP_FREE        = 2'd1;
  localparam logic [1:0] OP_MARK_FREE   = 2'd2;
  localparam logic [1:0] OP_MARK_SYSTEM = 2'd3;

  // request classes
  localparam logic [1:0] CLS_USER    = 2'd0;
  localparam logic [1:0] CLS_DRIVER  = 2'd1;
  localparam logic [1:0] CLS_KERNEL  = 2'd2;
  localparam logic [1:0] CLS_INVALID = 2'd3;

  // per-page state
  localparam logic [PSTATE_W-1:0] PS_UNASSIGNED = 2'd0;
  localparam logic [PSTATE_W-1:0] PS_FREE       = 2'd1;
  localparam logic [PSTATE_W-1:0] PS_INUSE      = 2'd2;
  localparam logic [PSTATE_W-1:0] PS_SYSTEM     = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] STS_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] STS_QUOTA       = 3'd1;
  localparam logic [STATUS_W-1:0] STS_KERN_OOM    = 3'd2;
  localparam logic [STATUS_W-1:0] STS_BAD_CLASS   = 3'd3;
  localparam logic [STATUS_W-1:0] STS_SYS_FREE    = 3'd4;
  localparam logic [STATUS_W-1:0] STS_UNUSED_FREE = 3'd5;
  localparam logic [STATUS_W-1:0] STS_MARKED      = 3'd6;

  // controller to datapath
  typedef struct packed {
    logic clr_step;  // clear one page state entry
    logic load;      // input transfer: latch item, read memories
    logic commit;    // execute item, update state, load result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
  } dp_sts_t;

endpackage

// ----- rtl/pfaq_ctrl.sv -----
module pfaq_ctrl
  import pfaq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_axis_tvalid,
  output logic    s_axis_tready,
  output logic    m_axis_tvalid,
  input  logic    m_axis_tready,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;

  // command decode and next state
  always_comb begin
    state_d        = state_q;
    cmd_o.clr_step = 1'b0;
    cmd_o.load     = 1'b0;
    cmd_o.commit   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_done) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.clr_step = 1'b1;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the output register can take the result
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    if (cmd_o.commit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/pfaq_dpath.sv -----
module pfaq_dpath
  import pfaq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [QUOTA_W-1:0]  cfg_data_i,
  input  logic [1:0]          operation_i,
  input  logic [1:0]          alloc_class_i,
  input  logic [IDX_W-1:0]    page_index_i,
  output logic [IDX_W-1:0]    granted_page_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [CNT_W-1:0]    free_count_o
);

  // memories
  logic [PSTATE_W-1:0] page_state_mem [NUM_PAGES];
  logic [IDX_W-1:0]    next_link_mem  [NUM_PAGES];

  logic [QUOTA_W-1:0]  driver_quota_q, kern_quota_q;
  logic [CNT_W-1:0]    clr_cnt_q;
  logic [IDX_W-1:0]    head_q, head_d;
  logic [CNT_W-1:0]    free_q, free_d;
  logic [1:0]          op_q, cls_q;
  logic [IDX_W-1:0]    pg_q;
  logic [PSTATE_W-1:0] ps_rd_q;
  logic [IDX_W-1:0]    nl_rd_q;

  logic                ps_we;
  logic [IDX_W-1:0]    ps_wa;
  logic [PSTATE_W-1:0] ps_wd;
  logic                nl_we;
  logic                exec_ps_we;
  logic [IDX_W-1:0]    exec_ps_wa;
  logic [PSTATE_W-1:0] exec_ps_wd;
  logic                push, pop;
  logic [STATUS_W-1:0] sts_d;
  logic [QUOTA_W:0]    user_limit;
  logic                pg_out_of_range;

  assign sts_o.clr_done  = (clr_cnt_q == CNT_W'(NUM_PAGES));
  assign user_limit      = {1'b0, driver_quota_q} + {1'b0, kern_quota_q};
  assign pg_out_of_range = ({1'b0, pg_q} >= CNT_W'(NUM_PAGES));

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      driver_quota_q <= DRIVER_QUOTA_RST;
      kern_quota_q   <= KERN_QUOTA_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DRIVER_QUOTA: driver_quota_q <= cfg_data_i;
        REG_KERN_QUOTA:   kern_quota_q   <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  // clear sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_cnt_q <= clr_cnt_q + CNT_W'(1);
    end
  end

  // item decode and execution
  always_comb begin
    sts_d      = STS_OK;
    push       = 1'b0;
    pop        = 1'b0;
    exec_ps_we = 1'b0;
    exec_ps_wa = pg_q;
    exec_ps_wd = PS_FREE;
    case (op_q)
      OP_ALLOC: begin
        case (cls_q)
          CLS_USER:   if ({1'b0, free_q} <= user_limit) sts_d = STS_QUOTA;
          CLS_DRIVER: if (free_q <= kern_quota_q) sts_d = STS_QUOTA;
          CLS_KERNEL: if (free_q == '0) sts_d = STS_KERN_OOM;
          default:    sts_d = STS_BAD_CLASS;
        endcase
        if (sts_d == STS_OK && {1'b0, head_q} >= CNT_W'(NUM_PAGES)) sts_d = STS_KERN_OOM;
        if (sts_d == STS_OK) begin
          pop        = 1'b1;
          exec_ps_we = 1'b1;
          exec_ps_wa = head_q;
          exec_ps_wd = PS_INUSE;
        end
      end
      OP_FREE: begin
        if (pg_out_of_range)             sts_d = STS_UNUSED_FREE;
        else if (ps_rd_q == PS_SYSTEM)   sts_d = STS_SYS_FREE;
        else if (ps_rd_q != PS_INUSE)    sts_d = STS_UNUSED_FREE;
        else                             push  = 1'b1;
      end
      OP_MARK_FREE, OP_MARK_SYSTEM: begin
        if (pg_out_of_range || ps_rd_q != PS_UNASSIGNED) begin
          sts_d = STS_MARKED;
        end else if (op_q == OP_MARK_FREE) begin
          push = 1'b1;
        end else begin
          exec_ps_we = 1'b1;
          exec_ps_wd = PS_SYSTEM;
        end
      end
      default: sts_d = STS_OK;
    endcase
    if (push) exec_ps_we = 1'b1;
  end

  // list head and free count
  always_comb begin
    head_d = head_q;
    free_d = free_q;
    if (pop) begin
      head_d = nl_rd_q;
      free_d = free_q - CNT_W'(1);
    end else if (push) begin
      head_d = pg_q;
      free_d = free_q + CNT_W'(1);
    end
  end

  // memory write port select
  always_comb begin
    if (cmd_i.clr_step) begin
      ps_we = 1'b1;
      ps_wa = clr_cnt_q[IDX_W-1:0];
      ps_wd = PS_UNASSIGNED;
    end else begin
      ps_we = cmd_i.commit && exec_ps_we;
      ps_wa = exec_ps_wa;
      ps_wd = exec_ps_wd;
    end
    nl_we = cmd_i.commit && push;
  end

  // page state memory
  always_ff @(posedge clk_i) begin
    if (ps_we) page_state_mem[ps_wa] <= ps_wd;
    if (cmd_i.load) ps_rd_q <= page_state_mem[page_index_i];
  end

  // next link memory
  always_ff @(posedge clk_i) begin
    if (nl_we) next_link_mem[pg_q] <= head_q;
    if (cmd_i.load) nl_rd_q <= next_link_mem[head_q];
  end

  // list control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      free_q <= '0;
    end else if (cmd_i.commit) begin
      head_q <= head_d;
      free_q <= free_d;
    end
  end

  // item and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= operation_i;
      cls_q <= alloc_class_i;
      pg_q  <= page_index_i;
    end
    if (cmd_i.commit) begin
      granted_page_o <= pop ? head_q : '0;
      status_o       <= sts_d;
      free_count_o   <= free_d;
    end
  end

endmodule

// ----- rtl/page_frame_allocator_quota_unit.sv -----
// Page frame allocator with class quotas.
// Input stream: one operation per transfer. s_axis_tuser carries operation
// and alloc_class, s_axis_tdata carries page_index. Output stream: one result
// per item with status in m_axis_tuser and granted page and free count in
// m_axis_tdata.
// Configuration: cfg_index_i 0 writes driver_quota, 1 writes kern_quota;
// cfg_ready_o is always high, write only while no item is in flight.
// Flow: at the input transfer the item is latched and the page state and
// the head's next link are read from the synchronous memories; the execute
// state then updates the list and loads the result register, waiting while
// the output register holds a result not yet taken. The next item
// is accepted in the cycle after the result is loaded.
// Reset: the page state memory is swept to unassigned, one entry a cycle,
// with s_axis_tready low; the list is empty and both quotas are 8.
// Stall: the result waits in an output register; one more item is accepted
// and then held before execution until that result has been taken.
module page_frame_allocator_quota_unit
  import pfaq_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [15:0]                s_axis_tdata,  // [9:0] page_index, zero fill
  input  logic [3:0]                 s_axis_tuser,  // [1:0] operation, [3:2] alloc_class
  // output stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [23:0]                m_axis_tdata,  // [9:0] granted_page, [20:10] free_count
  output logic [STATUS_W-1:0]        m_axis_tuser,  // [2:0] status
  // configuration writes
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_index_i,
  input  logic [QUOTA_W-1:0]         cfg_data_i
);

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [IDX_W-1:0] granted_page;
  logic [CNT_W-1:0] free_count;

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {3'b000, free_count, granted_page};

  pfaq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd),
    .sts_i         (sts)
  );

  pfaq_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .operation_i    (s_axis_tuser[1:0]),
    .alloc_class_i  (s_axis_tuser[3:2]),
    .page_index_i   (s_axis_tdata[IDX_W-1:0]),
    .granted_page_o (granted_page),
    .status_o       (m_axis_tuser),
    .free_count_o   (free_count)
  );

endmodule

// ----- rtl/pfaq_checker.sv -----
module pfaq_checker
  import pfaq_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [23:0]         m_axis_tdata,
  input logic [STATUS_W-1:0] m_axis_tuser
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // one item at a time: busy in the cycle after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item executes");

  // refused requests grant page zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != STS_OK |-> m_axis_tdata[IDX_W-1:0] == '0)
    else $error("failed item carries a page");

  // free count never exceeds the page count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[20:10] <= CNT_W'(NUM_PAGES))
    else $error("free count out of range");

endmodule

bind page_frame_allocator_quota_unit pfaq_checker u_pfaq_checker (.*);
